/* src/hal_pkg.sv */
// Shared types and constants for the hashed account ledger.
// No dependencies; used by hal_fmix and hashed_account_ledger_core.
package hal_pkg;

    localparam int HASH_DEPTH_DEF    = 4096;
    localparam int ACCOUNT_DEPTH_DEF = 2048;

    localparam int KEY_W  = 64;
    localparam int SLOT_W = 11;
    localparam int BAL_W  = 64;
    localparam int AMT_W  = 32;

    localparam int S_TDATA_W = 304;
    localparam int M_TDATA_W = 136;

    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int          FMIX_SHIFT = 33;

    typedef enum logic [2:0] {
        ST_LOADED   = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_APPLIED  = 3'd3,
        ST_NOFUNDS  = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_BAL_RS,
        S_BAL_RR,
        S_BAL_CHK,
        S_BAL_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] acct;
    } tbl_entry_t;

endpackage

/* src/hal_fmix.sv */
// Multi-cycle fmix64 finalizer built around one shared 32x32 multiplier.
// Depends on hal_pkg for the mixing constants.
module hal_fmix
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] key,
    output logic        done,
    output logic [63:0] hash
);

    logic        busy_reg;
    logic [2:0]  phase_reg;
    logic [63:0] k_reg;
    logic [63:0] acc_reg;
    logic        done_reg;
    logic [63:0] hash_reg;

    logic [1:0]  sub;
    logic        second;
    logic [63:0] cst;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] mixed;

    // phases 0..2 run the first multiply, 4..6 the second
    always_comb
    begin
        sub    = phase_reg[1:0];
        second = phase_reg[2];
        cst    = second ? hal_pkg::FMIX_C2 : hal_pkg::FMIX_C1;
        opa    = (sub == 2'd2) ? k_reg[63:32] : k_reg[31:0];
        opb    = (sub == 2'd1) ? cst[63:32] : cst[31:0];
        prod   = 64'(opa) * 64'(opb);
        sum    = (sub == 2'd0) ? prod : acc_reg + {prod[31:0], 32'd0};
        mixed  = sum ^ (sum >> hal_pkg::FMIX_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (sub == 2'd2)
                begin
                    if (second)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 3'd4;
                    end
                end
                else
                begin
                    phase_reg <= phase_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            k_reg <= key ^ (key >> hal_pkg::FMIX_SHIFT);
        end
        else if (busy_reg)
        begin
            acc_reg <= sum;
            if (sub == 2'd2)
            begin
                if (second)
                begin
                    hash_reg <= mixed;
                end
                else
                begin
                    k_reg <= mixed;
                end
            end
        end
    end

    assign done = done_reg;
    assign hash = hash_reg;

endmodule

/* src/hashed_account_ledger_core.sv */
// Account ledger: linear-probing hash index over a balance store.
// A load answers after hashing (and the slot reduction, where it runs) plus probing; a transfer
// after two hash-and-probe rounds plus the balance states BAL_RS, BAL_RR, BAL_CHK and BAL_WR.
// One word is in flight at a time.
// Reset: a clearing pass over all HASH_DEPTH entries empties the hash index; no word is taken meanwhile.
// Depends on hal_pkg and hal_fmix.
module hashed_account_ledger_core #(
    parameter int HASH_DEPTH    = hal_pkg::HASH_DEPTH_DEF,
    parameter int ACCOUNT_DEPTH = hal_pkg::ACCOUNT_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // account_address, account_slot, opening_balance, sender_address,
    // receiver_address, amount (low bit up), zero padded
    input  logic [hal_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, sender_balance, receiver_balance (low bit up), zero padded
    output logic [hal_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int HW        = $clog2(HASH_DEPTH);
    localparam int AW        = (ACCOUNT_DEPTH > 1) ? $clog2(ACCOUNT_DEPTH) : 1;
    localparam int MOD_STEPS = (ACCOUNT_DEPTH >= (1 << hal_pkg::SLOT_W)) ? 0 : hal_pkg::SLOT_W;
    localparam int MW        = 4;
    localparam logic [HW-1:0] POS_LAST = HW'(HASH_DEPTH - 1);

    // input word fields
    logic [63:0]                 f_acct_addr;
    logic [hal_pkg::SLOT_W-1:0]  f_slot;
    logic [63:0]                 f_obal;
    logic [63:0]                 f_sndr;
    logic [63:0]                 f_rcvr;
    logic [hal_pkg::AMT_W-1:0]   f_amt;

    assign f_acct_addr = s_tdata[63:0];
    assign f_slot      = s_tdata[74:64];
    assign f_obal      = s_tdata[138:75];
    assign f_sndr      = s_tdata[202:139];
    assign f_rcvr      = s_tdata[266:203];
    assign f_amt       = s_tdata[298:267];

    // control state
    hal_pkg::state_t             state_reg;
    hal_pkg::state_t             state_next;
    logic [HW-1:0]               clr_reg;
    logic                        which_reg;
    logic                        hdone_reg;
    logic [MW-1:0]               mod_cnt_reg;
    logic [HW-1:0]               cnt_reg;
    logic                        m_valid_reg;

    // payload
    logic                        func_reg;
    logic [63:0]                 key_reg;
    logic [63:0]                 rx_reg;
    logic [hal_pkg::SLOT_W-1:0]  slot_reg;
    logic [63:0]                 obal_reg;
    logic [hal_pkg::AMT_W-1:0]   amt_reg;
    logic [HW-1:0]               pos_reg;
    logic [hal_pkg::SLOT_W-1:0]  si_reg;
    logic [hal_pkg::SLOT_W-1:0]  ri_reg;
    logic [63:0]                 sb_reg;
    logic [63:0]                 rres_reg;
    logic                        wr_r_reg;
    hal_pkg::status_t            res_status_reg;
    logic [63:0]                 res_sb_reg;
    logic [63:0]                 res_rb_reg;
    hal_pkg::status_t            m_status_reg;
    logic [63:0]                 m_sb_reg;
    logic [63:0]                 m_rb_reg;

    // memories
    hal_pkg::tbl_entry_t         tbl_mem [HASH_DEPTH];
    hal_pkg::tbl_entry_t         tbl_q;
    logic [63:0]                 bal_mem [ACCOUNT_DEPTH];
    logic [63:0]                 bal_q;

    logic                        tbl_we;
    logic [HW-1:0]               tbl_waddr;
    hal_pkg::tbl_entry_t         tbl_wdata;
    logic [HW-1:0]               tbl_raddr;
    logic                        bal_we;
    logic [AW-1:0]               bal_waddr;
    logic [63:0]                 bal_wdata;
    logic [AW-1:0]               bal_raddr;

    // hash unit
    logic                        hash_start;
    logic [63:0]                 hash_key;
    logic                        hash_done;
    logic [63:0]                 hash_val;

    hal_fmix u_fmix
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .done  (hash_done),
        .hash  (hash_val)
    );

    // derived signals
    logic [HW-1:0]  start_pos;
    logic [HW-1:0]  pos_inc;
    logic           hit;
    logic           empty;
    logic           last;
    logic           hash_ready;
    logic           out_free;
    logic [MW-1:0]  mod_k;
    logic [32:0]    mod_div;
    logic           mod_ge;
    logic [63:0]    amt_ext;
    logic           funds_ok;
    logic           same_acct;
    logic           accept;

    always_comb
    begin
        start_pos  = hash_val[HW-1:0] & POS_LAST;
        pos_inc    = (pos_reg == POS_LAST) ? '0 : pos_reg + HW'(1);
        hit        = tbl_q.used && (tbl_q.key == key_reg);
        empty      = !tbl_q.used;
        last       = (cnt_reg == POS_LAST);
        hash_ready = hdone_reg || hash_done;
        out_free   = !m_valid_reg || m_tready;
        mod_k      = mod_cnt_reg - MW'(1);
        mod_div    = 33'(ACCOUNT_DEPTH) << mod_k;
        mod_ge     = 33'(slot_reg) >= mod_div;
        amt_ext    = 64'(amt_reg);
        funds_ok   = sb_reg >= amt_ext;
        same_acct  = (si_reg == ri_reg);
        accept     = s_tvalid && s_tready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hal_pkg::S_CLEAR:
            begin
                if (clr_reg == POS_LAST)
                begin
                    state_next = hal_pkg::S_IDLE;
                end
            end
            hal_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = hal_pkg::S_HASH;
                end
            end
            hal_pkg::S_HASH:
            begin
                if (hash_ready && (func_reg || (mod_cnt_reg == '0)))
                begin
                    state_next = hal_pkg::S_PROBE;
                end
            end
            hal_pkg::S_PROBE:
            begin
                priority if (hit)
                begin
                    if (!func_reg)
                    begin
                        state_next = hal_pkg::S_DONE;
                    end
                    else if (which_reg)
                    begin
                        state_next = hal_pkg::S_BAL_RS;
                    end
                    else
                    begin
                        state_next = hal_pkg::S_HASH;
                    end
                end
                else if (empty || last)
                begin
                    state_next = hal_pkg::S_DONE;
                end
                else
                begin
                    state_next = hal_pkg::S_PROBE;
                end
            end
            hal_pkg::S_BAL_RS:  state_next = hal_pkg::S_BAL_RR;
            hal_pkg::S_BAL_RR:  state_next = hal_pkg::S_BAL_CHK;
            hal_pkg::S_BAL_CHK: state_next = hal_pkg::S_BAL_WR;
            hal_pkg::S_BAL_WR:  state_next = hal_pkg::S_DONE;
            hal_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = hal_pkg::S_IDLE;
                end
            end
            default:            state_next = hal_pkg::S_IDLE;
        endcase
    end

    // outputs: memory ports, hash launch, input ready
    always_comb
    begin
        s_tready   = (state_reg == hal_pkg::S_IDLE);
        hash_start = 1'b0;
        hash_key   = rx_reg;
        tbl_raddr  = pos_reg;
        tbl_we     = 1'b0;
        tbl_waddr  = pos_reg;
        tbl_wdata  = '{used: 1'b1, key: key_reg, acct: slot_reg};
        bal_raddr  = AW'(si_reg);
        bal_we     = 1'b0;
        bal_waddr  = AW'(slot_reg);
        bal_wdata  = obal_reg;
        unique case (state_reg)
            hal_pkg::S_CLEAR:
            begin
                // sweep the index empty, one entry a cycle
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = '0;
            end
            hal_pkg::S_IDLE:
            begin
                hash_start = s_tvalid;
                hash_key   = s_tuser[0] ? f_sndr : f_acct_addr;
            end
            hal_pkg::S_HASH:
            begin
                // prefetch the home position of the key
                tbl_raddr = start_pos;
            end
            hal_pkg::S_PROBE:
            begin
                tbl_raddr = pos_inc;
                if (func_reg && hit && !which_reg)
                begin
                    hash_start = 1'b1;
                end
                if (!func_reg && (hit || empty))
                begin
                    // insert or retarget the key and store its opening balance
                    tbl_we = 1'b1;
                    bal_we = 1'b1;
                end
            end
            hal_pkg::S_BAL_RS:
            begin
                bal_raddr = AW'(si_reg);
            end
            hal_pkg::S_BAL_RR:
            begin
                bal_raddr = AW'(ri_reg);
            end
            hal_pkg::S_BAL_CHK:
            begin
                // debit the sender; same account on both sides leaves it alone
                bal_we    = funds_ok && !same_acct;
                bal_waddr = AW'(si_reg);
                bal_wdata = sb_reg - amt_ext;
            end
            hal_pkg::S_BAL_WR:
            begin
                bal_we    = wr_r_reg;
                bal_waddr = AW'(ri_reg);
                bal_wdata = rres_reg;
            end
            hal_pkg::S_DONE:
            begin
                tbl_raddr = pos_reg;
            end
            default:
            begin
                tbl_raddr = pos_reg;
            end
        endcase
    end

    // synchronous memories, registered read
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_q <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bal_we)
        begin
            bal_mem[bal_waddr] <= bal_wdata;
        end
        bal_q <= bal_mem[bal_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hal_pkg::S_CLEAR;
            clr_reg     <= '0;
            which_reg   <= 1'b0;
            hdone_reg   <= 1'b0;
            mod_cnt_reg <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hal_pkg::S_CLEAR)
            begin
                clr_reg <= clr_reg + HW'(1);
            end
            if (accept)
            begin
                which_reg   <= 1'b0;
                hdone_reg   <= 1'b0;
                mod_cnt_reg <= MW'(MOD_STEPS);
            end
            if (state_reg == hal_pkg::S_HASH)
            begin
                if (hash_done)
                begin
                    hdone_reg <= 1'b1;
                end
                if (mod_cnt_reg != '0)
                begin
                    mod_cnt_reg <= mod_k;
                end
                cnt_reg <= '0;
            end
            if (state_reg == hal_pkg::S_PROBE)
            begin
                if (func_reg && hit && !which_reg)
                begin
                    // sender found: go hash the receiver
                    which_reg <= 1'b1;
                    hdone_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + HW'(1);
            end
            if ((state_reg == hal_pkg::S_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= s_tuser[0];
            key_reg  <= hash_key;
            rx_reg   <= f_rcvr;
            slot_reg <= f_slot;
            obal_reg <= f_obal;
            amt_reg  <= f_amt;
        end
        if ((state_reg == hal_pkg::S_HASH) && (mod_cnt_reg != '0) && mod_ge)
        begin
            // restoring reduction of the slot, one bit position a cycle
            slot_reg <= slot_reg - hal_pkg::SLOT_W'(mod_div);
        end
        if ((state_reg == hal_pkg::S_HASH) && (state_next == hal_pkg::S_PROBE))
        begin
            pos_reg <= start_pos;
        end
        if (state_reg == hal_pkg::S_PROBE)
        begin
            pos_reg <= pos_inc;
            priority if (hit)
            begin
                if (!func_reg)
                begin
                    res_status_reg <= hal_pkg::ST_UPDATED;
                    res_sb_reg     <= obal_reg;
                    res_rb_reg     <= '0;
                end
                else if (which_reg)
                begin
                    ri_reg <= tbl_q.acct;
                end
                else
                begin
                    si_reg  <= tbl_q.acct;
                    key_reg <= rx_reg;
                end
            end
            else if (empty && !func_reg)
            begin
                res_status_reg <= hal_pkg::ST_LOADED;
                res_sb_reg     <= obal_reg;
                res_rb_reg     <= '0;
            end
            else if (empty || last)
            begin
                res_status_reg <= func_reg ? hal_pkg::ST_NOTFOUND : hal_pkg::ST_FULL;
                res_sb_reg     <= '0;
                res_rb_reg     <= '0;
            end
        end
        if (state_reg == hal_pkg::S_BAL_RR)
        begin
            sb_reg <= bal_q;
        end
        if (state_reg == hal_pkg::S_BAL_CHK)
        begin
            // bal_q holds the receiver balance here
            wr_r_reg <= funds_ok && !same_acct;
            rres_reg <= bal_q + amt_ext;
            if (!funds_ok)
            begin
                res_status_reg <= hal_pkg::ST_NOFUNDS;
                res_sb_reg     <= sb_reg;
                res_rb_reg     <= bal_q;
            end
            else if (same_acct)
            begin
                res_status_reg <= hal_pkg::ST_APPLIED;
                res_sb_reg     <= sb_reg;
                res_rb_reg     <= sb_reg;
            end
            else
            begin
                res_status_reg <= hal_pkg::ST_APPLIED;
                res_sb_reg     <= sb_reg - amt_ext;
                res_rb_reg     <= bal_q + amt_ext;
            end
        end
        if ((state_reg == hal_pkg::S_DONE) && out_free)
        begin
            m_status_reg <= res_status_reg;
            m_sb_reg     <= res_sb_reg;
            m_rb_reg     <= res_rb_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_rb_reg, m_sb_reg, m_status_reg};

endmodule
